[design/owp_pkg.sv]
// Shared types, constants and tables of the omnidirectional projection block.
package owp_pkg;

    localparam int MAX_COEFFS   = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int CITER_W      = $clog2(CORDIC_ITERS);
    localparam int COEF_IW      = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int CNT_W        = $clog2(MAX_COEFFS + 1);

    // configuration register indexes
    localparam logic [2:0] CFG_CENTER_FIRST  = 3'd0;
    localparam logic [2:0] CFG_CENTER_SECOND = 3'd1;
    localparam logic [2:0] CFG_AFFINE_C      = 3'd2;
    localparam logic [2:0] CFG_AFFINE_D      = 3'd3;
    localparam logic [2:0] CFG_AFFINE_E      = 3'd4;
    localparam logic [2:0] CFG_POLY_LENGTH   = 3'd5;

    // input word actions
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PROJECT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_MXX, S_MYY, S_SQRT, S_CORDIC, S_POLY_T, S_POLY_C, S_DIV,
        S_MCX, S_MCY, S_MBX, S_MBY, S_MF1, S_MF2, S_MF3, S_OUT
    } t_state;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [6:0]         sh;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] p;
    } t_mul_rsp;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:  v = 32'sh3243F6A8;
            5'd1:  v = 32'sh1DAC6705;
            5'd2:  v = 32'sh0FADBAFC;
            5'd3:  v = 32'sh07F56EA6;
            5'd4:  v = 32'sh03FEAB76;
            5'd5:  v = 32'sh01FFD55B;
            5'd6:  v = 32'sh00FFFAAA;
            5'd7:  v = 32'sh007FFF55;
            5'd8:  v = 32'sh003FFFEA;
            5'd9:  v = 32'sh001FFFFD;
            5'd10: v = 32'sh000FFFFF;
            5'd11: v = 32'sh0007FFFF;
            5'd12: v = 32'sh0003FFFF;
            5'd13: v = 32'sh0001FFFF;
            5'd14: v = 32'sh0000FFFF;
            5'd15: v = 32'sh00007FFF;
            5'd16: v = 32'sh00003FFF;
            5'd17: v = 32'sh00001FFF;
            5'd18: v = 32'sh00000FFF;
            5'd19: v = 32'sh000007FF;
            5'd20: v = 32'sh000003FF;
            5'd21: v = 32'sh000001FF;
            5'd22: v = 32'sh000000FF;
            5'd23: v = 32'sh0000007F;
            5'd24: v = 32'sh0000003F;
            5'd25: v = 32'sh0000001F;
            5'd26: v = 32'sh0000000F;
            5'd27: v = 32'sh00000008;
            5'd28: v = 32'sh00000004;
            5'd29: v = 32'sh00000002;
            5'd30: v = 32'sh00000001;
            default: v = 32'sh00000000;
        endcase
        return v;
    endfunction

    // true when v lies outside [-2^lg, 2^lg - 1]
    function automatic logic clip_hit(input logic signed [63:0] v, input logic [5:0] lg);
        logic signed [63:0] lim;
        lim = 64'sd1 <<< lg;
        return (v > lim - 64'sd1) || (v < -lim);
    endfunction

    function automatic logic signed [63:0] clip_val(input logic signed [63:0] v,
                                                    input logic [5:0] lg);
        logic signed [63:0] lim;
        lim = 64'sd1 <<< lg;
        if (v > lim - 64'sd1) begin
            return lim - 64'sd1;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

endpackage

[design/owp_mul.sv]
// Shared 64x64 rounding multiplier built from four 32x32 partial products.
module owp_mul import owp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [63:0]  r_ua, r_ub;
    logic         r_neg;
    logic [6:0]   r_sh;
    logic [127:0] r_acc;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [63:0]  r_p;

    logic [31:0]  a_part, b_part;
    logic [63:0]  pp;
    logic [127:0] pp_sh, rnd, acc_sh;
    logic [63:0]  mag_a, mag_b;

    // pick the partial product for this step
    assign a_part = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
    assign b_part = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
    assign pp     = {32'b0, a_part} * {32'b0, b_part};
    assign pp_sh  = {64'b0, pp} << {r_cnt[1] & r_cnt[0], r_cnt[1] ^ r_cnt[0], 5'd0};
    assign rnd    = (128'd1 << r_sh) >> 1;
    assign acc_sh = r_acc >> r_sh;
    assign mag_a  = i_req.a[63] ? 64'(-i_req.a) : 64'(i_req.a);
    assign mag_b  = i_req.b[63] ? 64'(-i_req.b) : 64'(i_req.b);

    // sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // accumulate, sign and round
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_ua  <= mag_a;
            r_ub  <= mag_b;
            r_neg <= i_req.a[63] ^ i_req.b[63];
            r_sh  <= i_req.sh;
            r_acc <= 128'd0;
        end else if (r_busy) begin
            case (r_cnt)
                3'd0, 3'd1, 3'd2, 3'd3: r_acc <= r_acc + pp_sh;
                3'd4: r_acc <= (r_neg ? ~r_acc : r_acc) + rnd + {127'b0, r_neg};
                default: r_p <= acc_sh[63:0];
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;

endmodule

[design/owp_sqrt.sv]
// Bit-pair integer square root, one result bit a cycle.
module owp_sqrt import owp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_norm,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_n, r_res;
    logic [4:0]  r_k;
    logic        r_busy, r_done;
    logic [63:0] bitv, trial;

    assign bitv  = 64'd1 << {r_k, 1'b0};
    assign trial = r_res + bitv;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 5'd31;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_busy <= 1'b1;
                r_k    <= 5'd31;
            end else if (r_busy) begin
                r_k <= r_k - 5'd1;
                if (r_k == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and root
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_n   <= i_norm;
            r_res <= 64'd0;
        end else if (r_busy) begin
            if (r_n >= trial) begin
                r_n   <= r_n - trial;
                r_res <= (r_res >> 1) + bitv;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

[design/owp_div.sv]
// Restoring divider for 2^62 / r, one quotient bit a cycle.
module owp_div import owp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [62:0] o_quot
);

    logic [31:0] r_rem, r_den;
    logic [62:0] r_q;
    logic [5:0]  r_k;
    logic        r_busy, r_done;
    logic [32:0] shifted;
    logic        ge;

    assign shifted = {r_rem, r_k == 6'd62};
    assign ge      = shifted >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 6'd62;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_busy <= 1'b1;
                r_k    <= 6'd62;
            end else if (r_busy) begin
                r_k <= r_k - 6'd1;
                if (r_k == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift, compare, subtract
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_rem <= 32'd0;
            r_den <= i_den;
            r_q   <= 63'd0;
        end else if (r_busy) begin
            r_rem <= ge ? 32'(shifted - {1'b0, r_den}) : shifted[31:0];
            r_q   <= {r_q[61:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[design/owp_cordic.sv]
// CORDIC vectoring unit: theta = atan(z / r) in Q2.30.
module owp_cordic import owp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_r,
    input  logic signed [31:0] i_z,
    output logic               o_done,
    output logic signed [31:0] o_theta
);

    logic signed [63:0] r_x, r_y;
    logic signed [31:0] r_th;
    logic [CITER_W-1:0] r_i;
    logic               r_busy, r_done;
    logic signed [63:0] sx, sy;
    logic signed [31:0] ang;

    assign sx  = r_x >>> r_i;
    assign sy  = r_y >>> r_i;
    assign ang = atan_q30(5'(r_i));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == CITER_W'(CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // rotate toward the axis
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_x  <= {8'b0, i_r, 24'b0};
            r_y  <= {{8{i_z[31]}}, i_z, 24'b0};
            r_th <= 32'sd0;
        end else if (r_busy) begin
            if (!r_y[63]) begin
                r_x  <= r_x + sy;
                r_y  <= r_y - sx;
                r_th <= r_th + ang;
            end else begin
                r_x  <= r_x - sy;
                r_y  <= r_y + sx;
                r_th <= r_th - ang;
            end
        end
    end

    assign o_done  = r_done;
    assign o_theta = r_th;

endmodule

[design/omnidirectional_world_to_pixel.sv]
// Top level: sequencer of the fisheye world-to-pixel projection.
//
//  channel | direction | handshake                    | words
//  input   | in        | i_in_valid / o_in_stall      | load coefficient or project point
//  output  | out       | o_out_valid / i_out_stall    | image coordinates and flags
//  config  | in        | i_cfg_wr_en                  | one register per write
//
// A load word leaves the sequencer idle; an on-axis point goes straight to the output state.
// A projection runs through the square root (32 steps), CORDIC (24 steps),
// the divider (63 steps) and the shared multiplier, whose share of the work
// grows with poly_length.
// Reset is synchronous, active low, and clears control and configuration.
// The input stalls while a point is in work; a finished word waits in the
// output register while the next input word is taken.
module omnidirectional_world_to_pixel import owp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [3:0]         i_coef_index,
    input  logic signed [47:0] i_coef_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_first,
    output logic signed [31:0] o_out_second,
    output logic               o_on_axis,
    output logic               o_saturated
);

    t_state r_state, n_state;

    logic signed [31:0] r_center_first, r_center_second;
    logic signed [31:0] r_affine_c, r_affine_d, r_affine_e;
    logic [4:0]         r_poly_length;
    logic signed [47:0] r_coef [MAX_COEFFS];

    logic signed [31:0] r_x, r_y, r_z;
    logic [63:0]        r_norm;
    logic [31:0]        r_r;
    logic signed [31:0] r_theta;
    logic signed [63:0] r_tpow, r_rho;
    logic [62:0]        r_inv;
    logic signed [63:0] r_cx, r_cy, r_bx, r_by, r_m1, r_m2;
    logic [CNT_W-1:0]   r_pidx;
    logic               r_issued;
    logic signed [31:0] r_f, r_s;
    logic               r_axis, r_sat;
    logic               r_out_valid;
    logic signed [31:0] r_out_first, r_out_second;
    logic               r_out_axis, r_out_sat;

    t_mul_req           mul_req;
    t_mul_rsp           mul_rsp;
    logic               sqrt_start, sqrt_done;
    logic [31:0]        sqrt_root;
    logic               div_start, div_done;
    logic [62:0]        div_quot;
    logic               cor_start, cor_done;
    logic signed [31:0] cor_theta;

    logic               in_acc, out_acc, out_free, unit_done, start;
    logic [CNT_W-1:0]   plen;
    logic signed [63:0] rho_sum, f_sum, s_sum;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign start    = !r_issued;

    // clamp the term count to 1 .. MAX_COEFFS
    assign plen = (r_poly_length == 5'd0) ? CNT_W'(1) :
                  ({27'b0, r_poly_length} > MAX_COEFFS) ? CNT_W'(MAX_COEFFS) :
                  CNT_W'(r_poly_length);

    assign rho_sum = r_rho + mul_rsp.p;
    assign f_sum   = r_m1 + r_m2 + 64'(r_center_first);
    assign s_sum   = mul_rsp.p + r_by + 64'(r_center_second);

    // select multiplier operands and sequence the work
    always_comb begin
        n_state      = r_state;
        mul_req      = '0;
        sqrt_start   = 1'b0;
        div_start    = 1'b0;
        cor_start    = 1'b0;
        unit_done    = mul_rsp.done;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_action == ACT_PROJECT) begin
                    n_state = (i_point_x == 32'sd0 && i_point_y == 32'sd0) ? S_OUT : S_MXX;
                end
            end
            S_MXX: begin
                mul_req = '{start, 64'(r_x), 64'(r_x), 7'd0};
                if (unit_done) n_state = S_MYY;
            end
            S_MYY: begin
                mul_req = '{start, 64'(r_y), 64'(r_y), 7'd0};
                if (unit_done) n_state = S_SQRT;
            end
            S_SQRT: begin
                sqrt_start = start;
                unit_done  = sqrt_done;
                if (unit_done) n_state = S_CORDIC;
            end
            S_CORDIC: begin
                cor_start = start;
                unit_done = cor_done;
                if (unit_done) n_state = (plen > CNT_W'(1)) ? S_POLY_T : S_DIV;
            end
            S_POLY_T: begin
                mul_req = '{start, r_tpow, 64'(r_theta), 7'd30};
                if (unit_done) n_state = S_POLY_C;
            end
            S_POLY_C: begin
                mul_req = '{start, 64'(r_coef[r_pidx[COEF_IW-1:0]]), r_tpow, 7'd30};
                if (unit_done) n_state = (r_pidx + 1'b1 < plen) ? S_POLY_T : S_DIV;
            end
            S_DIV: begin
                div_start = start;
                unit_done = div_done;
                if (unit_done) n_state = S_MCX;
            end
            S_MCX: begin
                mul_req = '{start, 64'(r_x), {1'b0, r_inv}, 7'd32};
                if (unit_done) n_state = S_MCY;
            end
            S_MCY: begin
                mul_req = '{start, 64'(r_y), {1'b0, r_inv}, 7'd32};
                if (unit_done) n_state = S_MBX;
            end
            S_MBX: begin
                mul_req = '{start, r_cx, r_rho, 7'd38};
                if (unit_done) n_state = S_MBY;
            end
            S_MBY: begin
                mul_req = '{start, r_cy, r_rho, 7'd38};
                if (unit_done) n_state = S_MF1;
            end
            S_MF1: begin
                mul_req = '{start, r_bx, 64'(r_affine_c), 7'd30};
                if (unit_done) n_state = S_MF2;
            end
            S_MF2: begin
                mul_req = '{start, r_by, 64'(r_affine_d), 7'd30};
                if (unit_done) n_state = S_MF3;
            end
            S_MF3: begin
                mul_req = '{start, r_bx, 64'(r_affine_e), 7'd30};
                if (unit_done) n_state = S_OUT;
            end
            S_OUT: begin
                unit_done = 1'b0;
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register, unit handshake and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (unit_done) begin
                r_issued <= 1'b0;
            end else if (mul_req.start || sqrt_start || div_start || cor_start) begin
                r_issued <= 1'b1;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_first  <= 32'sd0;
            r_center_second <= 32'sd0;
            r_affine_c      <= 32'sd1073741824;
            r_affine_d      <= 32'sd0;
            r_affine_e      <= 32'sd0;
            r_poly_length   <= 5'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CENTER_FIRST:  r_center_first  <= i_cfg_data;
                CFG_CENTER_SECOND: r_center_second <= i_cfg_data;
                CFG_AFFINE_C:      r_affine_c      <= i_cfg_data;
                CFG_AFFINE_D:      r_affine_d      <= i_cfg_data;
                CFG_AFFINE_E:      r_affine_e      <= i_cfg_data;
                CFG_POLY_LENGTH:   r_poly_length   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // coefficient table
    always_ff @(posedge i_clk) begin
        if (in_acc && i_action == ACT_LOAD) begin
            r_coef[COEF_IW'(i_coef_index)] <= i_coef_value;
        end
    end

    // datapath: capture each unit result
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_action == ACT_PROJECT) begin
                    r_x    <= i_point_x;
                    r_y    <= i_point_y;
                    r_z    <= i_point_z;
                    r_f    <= r_center_first;
                    r_s    <= r_center_second;
                    r_axis <= (i_point_x == 32'sd0 && i_point_y == 32'sd0);
                    r_sat  <= 1'b0;
                end
            end
            S_MXX: if (unit_done) r_norm <= mul_rsp.p;
            S_MYY: if (unit_done) r_norm <= r_norm + mul_rsp.p;
            S_SQRT: if (unit_done) r_r <= sqrt_root;
            S_CORDIC: begin
                if (unit_done) begin
                    r_theta <= cor_theta;
                    r_rho   <= 64'(r_coef[0]);
                    r_tpow  <= 64'sd1 <<< 30;
                    r_pidx  <= CNT_W'(1);
                end
            end
            S_POLY_T: begin
                if (unit_done) begin
                    r_tpow <= clip_val(mul_rsp.p, 6'd45);
                    r_sat  <= r_sat | clip_hit(mul_rsp.p, 6'd45);
                end
            end
            S_POLY_C: begin
                if (unit_done) begin
                    r_rho  <= clip_val(rho_sum, 6'd47);
                    r_sat  <= r_sat | clip_hit(rho_sum, 6'd47);
                    r_pidx <= r_pidx + 1'b1;
                end
            end
            S_DIV: if (unit_done) r_inv <= div_quot;
            S_MCX: if (unit_done) r_cx <= mul_rsp.p;
            S_MCY: if (unit_done) r_cy <= mul_rsp.p;
            S_MBX: if (unit_done) r_bx <= mul_rsp.p;
            S_MBY: if (unit_done) r_by <= mul_rsp.p;
            S_MF1: if (unit_done) r_m1 <= mul_rsp.p;
            S_MF2: if (unit_done) r_m2 <= mul_rsp.p;
            S_MF3: begin
                if (unit_done) begin
                    r_f   <= 32'(clip_val(f_sum, 6'd31));
                    r_s   <= 32'(clip_val(s_sum, 6'd31));
                    r_sat <= r_sat | clip_hit(f_sum, 6'd31) | clip_hit(s_sum, 6'd31);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_first  <= r_f;
                    r_out_second <= r_s;
                    r_out_axis   <= r_axis;
                    r_out_sat    <= r_sat;
                end
            end
            default: ;
        endcase
    end

    owp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    owp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_norm  (r_norm),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    owp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_r     (r_r),
        .i_z     (r_z),
        .o_done  (cor_done),
        .o_theta (cor_theta)
    );

    owp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_den   (r_r),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_first  = r_out_first;
    assign o_out_second = r_out_second;
    assign o_on_axis    = r_out_axis;
    assign o_saturated  = r_out_sat;

    // a load word leaves the sequencer idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_action == ACT_LOAD) |=> r_state == S_IDLE)
        else $error("load word started a projection");

    // an on-axis word never reports clipping
    a_axis_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_on_axis) |-> !o_saturated)
        else $error("on-axis word flagged saturated");

    // a multiplier result only arrives for a request in flight
    a_mul_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> r_issued)
        else $error("multiplier result without request");

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the fisheye world-to-pixel projection block.
`timescale 1ns / 100ps

module tb_top;
    import owp_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int SETTLE_CYCLES = 600;

    typedef struct packed {
        logic signed [31:0] first;
        logic signed [31:0] second;
        logic               on_axis;
        logic               saturated;
    } t_pixel;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_action;
    logic [3:0]         i_coef_index;
    logic signed [47:0] i_coef_value;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic signed [31:0] i_point_z;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_out_first;
    logic signed [31:0] o_out_second;
    logic               o_on_axis;
    logic               o_saturated;

    omnidirectional_world_to_pixel i_dut (.*);

    // shadow copy of the block's configuration and coefficient table
    logic signed [31:0] cal_center_first, cal_center_second;
    logic signed [31:0] cal_affine_c, cal_affine_d, cal_affine_e;
    logic [4:0]         cal_poly_len;
    logic signed [47:0] coef_mem [MAX_COEFFS];

    t_pixel pixel_queue[$];
    int     errors;
    int     cycles;
    int     tx_idle_pct;
    int     rx_idle_pct;

    // atan(2^-i) in Q2.30, truncated
    logic signed [63:0] atan_tab [32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // exact product, rounded half up, kept to 64 bits
    function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int sh);
        logic signed [127:0] pa, pb, p;
        pa = a;
        pb = b;
        p = pa * pb + (128'sd1 <<< (sh - 1));
        p = p >>> sh;
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] clip_to(input logic signed [63:0] v,
                                                   input int lg, inout logic sat);
        logic signed [63:0] lim;
        lim = 64'sd1 <<< lg;
        if (v > lim - 64'sd1) begin
            sat = 1'b1;
            return lim - 64'sd1;
        end
        if (v < -lim) begin
            sat = 1'b1;
            return -lim;
        end
        return v;
    endfunction

    function automatic logic [63:0] sqrt_floor(input logic [63:0] n);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt = bt >> 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n = n - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // expected image coordinates of one point
    function automatic t_pixel project_point(input logic signed [31:0] px,
                                             input logic signed [31:0] py,
                                             input logic signed [31:0] pz);
        t_pixel             pix;
        logic signed [63:0] x, y, z, r, vx, vy, nx, theta, tp, rho, cx, cy, bx, by, f, s;
        logic [63:0]        norm, inv;
        int                 len;
        logic               sat;
        x = px;
        y = py;
        z = pz;
        sat = 1'b0;
        norm = x * x + y * y;
        if (norm == 0) begin
            pix.first = cal_center_first;
            pix.second = cal_center_second;
            pix.on_axis = 1'b1;
            pix.saturated = 1'b0;
            return pix;
        end
        r = sqrt_floor(norm);
        // vector (r, z) onto the axis to get the elevation angle
        vx = r <<< 24;
        vy = z <<< 24;
        theta = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (vy >= 0) begin
                nx = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                theta = theta + atan_tab[i];
            end else begin
                nx = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                theta = theta - atan_tab[i];
            end
            vx = nx;
        end
        len = (cal_poly_len > MAX_COEFFS) ? MAX_COEFFS : cal_poly_len;
        rho = coef_mem[0];
        tp = 64'sd1 <<< 30;
        for (int i = 1; i < len; i++) begin
            tp = clip_to(mul_round(tp, theta, 30), 45, sat);
            rho = clip_to(rho + mul_round(coef_mem[i], tp, 30), 47, sat);
        end
        inv = (64'd1 << 62) / r;
        cx = mul_round(x, inv, 32);
        cy = mul_round(y, inv, 32);
        bx = mul_round(cx, rho, 38);
        by = mul_round(cy, rho, 38);
        f = mul_round(bx, cal_affine_c, 30) + mul_round(by, cal_affine_d, 30)
            + 64'(cal_center_first);
        s = mul_round(bx, cal_affine_e, 30) + by + 64'(cal_center_second);
        f = clip_to(f, 31, sat);
        s = clip_to(s, 31, sat);
        pix.first = f[31:0];
        pix.second = s[31:0];
        pix.on_axis = 1'b0;
        pix.saturated = sat;
        return pix;
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // random back-pressure on the result side
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixel_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected word first=%h second=%h axis=%b sat=%b", $time,
                         o_out_first, o_out_second, o_on_axis, o_saturated);
            end else begin
                want = pixel_queue.pop_front();
                if (o_out_first !== want.first) begin
                    errors++;
                    $display("%0t: out_first expected %h actual %h", $time, want.first,
                             o_out_first);
                end
                if (o_out_second !== want.second) begin
                    errors++;
                    $display("%0t: out_second expected %h actual %h", $time, want.second,
                             o_out_second);
                end
                if (o_on_axis !== want.on_axis) begin
                    errors++;
                    $display("%0t: on_axis expected %b actual %b", $time, want.on_axis,
                             o_on_axis);
                end
                if (o_saturated !== want.saturated) begin
                    errors++;
                    $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                             o_saturated);
                end
            end
        end
    end

    // send one input word and record what it should produce
    task automatic send_word(input logic act, input logic [3:0] idx,
                             input logic signed [47:0] val, input logic signed [31:0] px,
                             input logic signed [31:0] py, input logic signed [31:0] pz);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_action <= act;
        i_coef_index <= idx;
        i_coef_value <= val;
        i_point_x <= px;
        i_point_y <= py;
        i_point_z <= pz;
        do @(posedge i_clk); while (o_in_stall);
        if (act == ACT_LOAD) begin
            coef_mem[idx] = val;
        end else begin
            pixel_queue.push_back(project_point(px, py, pz));
        end
    endtask

    task automatic load_coef(input logic [3:0] idx, input logic signed [47:0] val);
        send_word(ACT_LOAD, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic project(input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic signed [31:0] pz);
        send_word(ACT_PROJECT, 4'($urandom), 48'({$urandom, $urandom}), px, py, pz);
    endtask

    // drop valid and wait out every pending result
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_CENTER_FIRST:  cal_center_first = data;
            CFG_CENTER_SECOND: cal_center_second = data;
            CFG_AFFINE_C:      cal_affine_c = data;
            CFG_AFFINE_D:      cal_affine_d = data;
            CFG_AFFINE_E:      cal_affine_e = data;
            CFG_POLY_LENGTH:   cal_poly_len = data[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_calibration(input logic [31:0] xc, input logic [31:0] yc,
                                   input logic [31:0] c, input logic [31:0] d,
                                   input logic [31:0] e, input logic [4:0] len);
        write_reg(CFG_CENTER_FIRST, xc);
        write_reg(CFG_CENTER_SECOND, yc);
        write_reg(CFG_AFFINE_C, c);
        write_reg(CFG_AFFINE_D, d);
        write_reg(CFG_AFFINE_E, e);
        write_reg(CFG_POLY_LENGTH, {27'd0, len});
    endtask

    // plausible lens polynomial: large constant term, shrinking higher terms
    function automatic logic signed [47:0] lens_coef(input int i);
        logic signed [47:0] v;
        v = 48'({$urandom, $urandom});
        return v >>> (i == 0 ? 14 : $urandom_range(20 + i, 47));
    endfunction

    // point coordinate mostly of moderate size, sometimes any 32-bit value
    function automatic logic signed [31:0] coord();
        logic signed [31:0] v;
        v = $urandom;
        return ($urandom_range(9) < 2) ? v : v >>> $urandom_range(4, 30);
    endfunction

    // fill the whole coefficient table so that no unwritten entry is read
    task automatic test_table_load();
        load_coef(4'd0, 48'sh7FFF_FFFF_FFFF);
        load_coef(4'd1, 48'sh8000_0000_0000);
        for (int i = 0; i < MAX_COEFFS; i++) load_coef(i[3:0], lens_coef(i));
    endtask

    task automatic test_point_extremes();
        project(32'sd0, 32'sd0, 32'sh7FFF_FFFF);
        project(32'sd0, 32'sd0, 32'sh8000_0000);
        project(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        project(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        project(32'sd1, 32'sd0, 32'sd0);
        project(32'sd0, -32'sd1, 32'sh7FFF_FFFF);
        project(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
        drain();
    endtask

    // run two fixed points and one random point through corner calibrations, polynomial length extremes included
    task automatic test_calibration_sweep();
        logic [4:0] lens [5] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
        for (int k = 0; k < 5; k++) begin
            set_calibration(k[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                            k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                            k[1] ? 32'h8000_0000 : 32'h4000_0000,
                            $urandom, $urandom, lens[k]);
            project(32'sh0100_0000, -32'sh0080_0000, 32'sh0040_0000);
            project(32'sd0, 32'sd0, 32'sd5);
            project(coord(), coord(), coord());
            drain();
        end
    endtask

    // random lens calibration, mostly realistic points, with on-axis points and table reloads mixed in
    task automatic test_random_phase(input int n_words);
        set_calibration($urandom >> 20 << 16 ^ $urandom_range(65535),
                        $urandom >> 20 << 16 ^ $urandom_range(65535),
                        32'h4000_0000 + ($urandom >> 8) - 32'h0080_0000,
                        $urandom >>> 10, $urandom >>> 10,
                        ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 6)));
        for (int i = 0; i < n_words; i++) begin
            case ($urandom_range(19))
                0, 1, 2: load_coef(4'($urandom), ($urandom_range(7) == 0)
                                   ? 48'({$urandom, $urandom}) : lens_coef($urandom_range(15)));
                3:       project(32'sd0, 32'sd0, $urandom);
                4:       project($urandom, $urandom, $urandom);
                default: project(coord(), coord(), coord());
            endcase
        end
        drain();
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_action = ACT_LOAD;
        i_coef_index = '0;
        i_coef_value = '0;
        i_point_x = '0;
        i_point_y = '0;
        i_point_z = '0;
        cal_center_first = 0;
        cal_center_second = 0;
        cal_affine_c = 32'sh4000_0000;
        cal_affine_d = 0;
        cal_affine_e = 0;
        cal_poly_len = 5'd1;
        for (int i = 0; i < MAX_COEFFS; i++) coef_mem[i] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_table_load();
        test_point_extremes();
        test_calibration_sweep();

        tx_idle_pct = 15;
        rx_idle_pct = 85;
        test_random_phase(580);
        tx_idle_pct = 85;
        rx_idle_pct = 15;
        test_random_phase(580);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_phase(580);

        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

[files.f]
design/owp_pkg.sv
design/owp_mul.sv
design/owp_sqrt.sv
design/owp_div.sv
design/owp_cordic.sv
design/omnidirectional_world_to_pixel.sv
tb/tb_top.sv
